@@ design/ufs_pkg.sv @@
package ufs_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
	} url_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       byte_valid;
		logic       done_res;
		logic [2:0] status;
		logic       last_of_run;
	} seg_res_t;

	typedef enum logic [3:0] {
		PH_SCHEME     = 4'd0,
		PH_SCHEME_BAD = 4'd1,
		PH_SLASH1     = 4'd2,
		PH_SLASH2     = 4'd3,
		PH_AUTH       = 4'd4,
		PH_HOST       = 4'd5,
		PH_PORT       = 4'd6,
		PH_PATH       = 4'd7,
		PH_QUERY      = 4'd8,
		PH_FRAG       = 4'd9,
		PH_ERR        = 4'd10
	} phase_t;

	typedef enum logic {
		SQ_RUN,
		SQ_REPLAY
	} seq_t;

	typedef enum logic [1:0] {
		RK_USER,
		RK_HOST,
		RK_END
	} kind_t;

	localparam logic [2:0] TAG_SCHEME = 3'd0;
	localparam logic [2:0] TAG_USER   = 3'd1;
	localparam logic [2:0] TAG_PASS   = 3'd2;
	localparam logic [2:0] TAG_HOST   = 3'd3;
	localparam logic [2:0] TAG_PORT   = 3'd4;
	localparam logic [2:0] TAG_PATH   = 3'd5;
	localparam logic [2:0] TAG_QUERY  = 3'd6;
	localparam logic [2:0] TAG_FRAG   = 3'd7;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_SCHEME = 3'd1;
	localparam logic [2:0] ST_NO_COLON   = 3'd2;
	localparam logic [2:0] ST_NO_SLASH   = 3'd3;
	localparam logic [2:0] ST_EMPTY_HOST = 3'd4;
	localparam logic [2:0] ST_BAD_AFTER  = 3'd5;
	localparam logic [2:0] ST_OVERFLOW   = 3'd6;

	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_AT       = 8'h40;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_LBR      = 8'h5B;
	localparam logic [7:0] CH_RBR      = 8'h5D;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CH_LOWER_A  = 8'h61;
	localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic colon;
		logic slash;
		logic at;
		logic lbr;
		logic rbr;
		logic qmark;
		logic hash;
		logic scheme_ok;
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t cls;
		logic      is_end;
		logic      full;
		logic      more;
		logic      rv;
		logic      pend_ok;
	} dp_stat_t;

	typedef struct packed {
		logic       step;
		logic       emit;
		logic       lower;
		logic [2:0] tag;
		logic       done;
		logic [2:0] status;
		logic       run_end;
		logic       wr;
		logic       clr_cnt;
		logic       rd_start;
		logic       rd_go;
	} dp_cmd_t;

endpackage

@@ design/ufs_ram.sv @@
module ufs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/ufs_dp.sv @@
module ufs_dp import ufs_pkg::*; #(
	parameter int AUTH_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  url_req_t url_data,
	input  logic     replay,
	input  dp_cmd_t  cmd,
	output dp_stat_t stat,
	output logic     seg_valid,
	input  logic     seg_stall,
	output seg_res_t seg_data
);

	localparam int AW = $clog2(AUTH_DEPTH);
	localparam int CW = $clog2(AUTH_DEPTH + 1);

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rd_ptr_q;
	logic          rv_q;
	logic [7:0]    rd_data;
	logic [7:0]    cur;
	logic          is_upper;
	logic          is_lower;
	logic          more;
	logic          re;
	logic          out_v_q;
	logic          pend_v_q;
	seg_res_t      out_q;
	seg_res_t      pend_q;
	seg_res_t      new_r;
	logic          new_v;
	logic          out_free;
	logic          pend_move;

	assign cur      = !replay ? url_data.in_byte : (rv_q ? rd_data : CH_SLASH);
	assign is_upper = (cur >= CH_UPPER_A) && (cur <= CH_UPPER_Z);
	assign is_lower = (cur >= CH_LOWER_A) && (cur <= CH_LOWER_Z);
	assign more     = rd_ptr_q < cnt_q;
	assign re       = cmd.step && cmd.rd_go && more;

	ufs_ram #(
		.WIDTH(8),
		.DEPTH(AUTH_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.step && cmd.wr),
		.waddr(cnt_q[AW-1:0]),
		.wdata(url_data.in_byte),
		.re   (re),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign out_free  = !out_v_q || !seg_stall;
	assign new_v     = cmd.step && (cmd.emit || cmd.done);
	assign pend_move = pend_v_q && out_free && (pend_q.last_of_run || new_v);

	always_comb begin
		stat.cls.colon     = cur == CH_COLON;
		stat.cls.slash     = cur == CH_SLASH;
		stat.cls.at        = cur == CH_AT;
		stat.cls.lbr       = cur == CH_LBR;
		stat.cls.rbr       = cur == CH_RBR;
		stat.cls.qmark     = cur == CH_QMARK;
		stat.cls.hash      = cur == CH_HASH;
		stat.cls.scheme_ok = is_upper || is_lower || (cur == CH_PLUS) ||
			(cur == CH_MINUS) || (cur == CH_DOT);
		stat.is_end        = url_data.is_end;
		stat.full          = cnt_q == CW'(AUTH_DEPTH);
		stat.more          = more;
		stat.rv            = rv_q;
		stat.pend_ok       = !pend_v_q || out_free;
	end

	always_comb begin
		new_r.out_byte    = cmd.done ? '0 :
			((cmd.lower && is_upper) ? cur + CASE_OFFSET : cur);
		new_r.field_tag   = cmd.done ? TAG_SCHEME : cmd.tag;
		new_r.byte_valid  = !cmd.done;
		new_r.done_res    = cmd.done;
		new_r.status      = cmd.done ? cmd.status : ST_OK;
		new_r.last_of_run = cmd.run_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			rv_q     <= 1'b0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.step && cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.step && cmd.wr) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.step && cmd.rd_start) begin
				rd_ptr_q <= '0;
				rv_q     <= 1'b0;
			end else if (cmd.step && cmd.rd_go) begin
				rv_q <= more;
				if (more) begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
			end
			if (pend_move) begin
				out_v_q <= 1'b1;
			end else if (out_free) begin
				out_v_q <= 1'b0;
			end
			if (new_v) begin
				pend_v_q <= 1'b1;
			end else if (pend_move) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_v) begin
			pend_q <= new_r;
		end else if (cmd.step && cmd.run_end && pend_v_q) begin
			pend_q.last_of_run <= 1'b1;
		end
		if (pend_move) begin
			out_q <= pend_q;
		end
	end

	assign seg_valid = out_v_q;
	assign seg_data  = out_q;

endmodule

@@ design/ufs_ctrl.sv @@
module ufs_ctrl import ufs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     url_valid,
	output logic     url_stall,
	output logic     replay,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	phase_t     phase_q, phase_d;
	seq_t       seq_q, seq_d;
	kind_t      kind_q, kind_d;
	logic       split_q, split_d;
	logic       bm_q, bm_d;
	logic       bc_q, bc_d;
	logic       hn_q, hn_d;
	logic [2:0] err_q, err_d;

	phase_t     f_phase;
	logic       f_bm;
	logic       f_bc;
	logic       f_hn;
	logic [2:0] f_err;
	logic       f_emit;
	logic [2:0] f_tag;

	function automatic logic [2:0] end_status(phase_t p, logic hn, logic [2:0] e);
		logic [2:0] s;
		unique case (p) inside
			PH_SCHEME, PH_SCHEME_BAD: s = ST_NO_COLON;
			PH_SLASH1, PH_SLASH2:     s = ST_NO_SLASH;
			PH_HOST:                  s = hn ? ST_OK : ST_EMPTY_HOST;
			PH_PORT, PH_PATH, PH_QUERY, PH_FRAG: s = ST_OK;
			default:                  s = e;
		endcase
		return s;
	endfunction

	assign url_stall = !((seq_q == SQ_RUN) && stat.pend_ok);
	assign replay    = seq_q == SQ_REPLAY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCHEME;
			seq_q   <= SQ_RUN;
			kind_q  <= RK_USER;
			split_q <= 1'b0;
			bm_q    <= 1'b0;
			bc_q    <= 1'b0;
			hn_q    <= 1'b0;
			err_q   <= ST_OK;
		end else begin
			phase_q <= phase_d;
			seq_q   <= seq_d;
			kind_q  <= kind_d;
			split_q <= split_d;
			bm_q    <= bm_d;
			bc_q    <= bc_d;
			hn_q    <= hn_d;
			err_q   <= err_d;
		end
	end

	// host, port, path, query and fragment byte handling
	always_comb begin
		f_phase = phase_q;
		f_bm    = bm_q;
		f_bc    = bc_q;
		f_hn    = hn_q;
		f_err   = err_q;
		f_emit  = 1'b0;
		f_tag   = TAG_HOST;
		unique case (phase_q)
			PH_HOST: begin
				if (bm_q && !bc_q) begin
					f_emit = 1'b1;
					if (stat.cls.rbr) begin
						f_bc = 1'b1;
					end
				end else if (bc_q) begin
					if (stat.cls.colon) begin
						f_phase = PH_PORT;
					end else if (stat.cls.slash) begin
						f_phase = PH_PATH;
					end else begin
						f_phase = PH_ERR;
						f_err   = ST_BAD_AFTER;
					end
				end else if (stat.cls.colon || stat.cls.slash) begin
					if (!hn_q) begin
						f_phase = PH_ERR;
						f_err   = ST_EMPTY_HOST;
					end else begin
						f_phase = stat.cls.colon ? PH_PORT : PH_PATH;
					end
				end else begin
					if (!hn_q && stat.cls.lbr) begin
						f_bm = 1'b1;
					end
					f_emit = 1'b1;
					f_hn   = 1'b1;
				end
			end
			PH_PORT: begin
				f_tag = TAG_PORT;
				if (stat.cls.slash) begin
					f_phase = PH_PATH;
				end else begin
					f_emit = 1'b1;
				end
			end
			PH_PATH: begin
				f_tag = TAG_PATH;
				if (stat.cls.qmark) begin
					f_phase = PH_QUERY;
				end else if (stat.cls.hash) begin
					f_phase = PH_FRAG;
				end else begin
					f_emit = 1'b1;
				end
			end
			PH_QUERY: begin
				f_tag = TAG_QUERY;
				if (stat.cls.hash) begin
					f_phase = PH_FRAG;
				end else begin
					f_emit = 1'b1;
				end
			end
			PH_FRAG: begin
				f_tag  = TAG_FRAG;
				f_emit = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		kind_d  = kind_q;
		split_d = split_q;
		bm_d    = bm_q;
		bc_d    = bc_q;
		hn_d    = hn_q;
		err_d   = err_q;
		cmd     = '0;
		unique case (seq_q)
			SQ_RUN: begin
				if (url_valid && stat.pend_ok) begin
					cmd.step    = 1'b1;
					cmd.run_end = 1'b1;
					if (stat.is_end) begin
						if (phase_q == PH_AUTH) begin
							cmd.run_end  = 1'b0;
							cmd.rd_start = 1'b1;
							seq_d        = SQ_REPLAY;
							kind_d       = RK_END;
							phase_d      = PH_HOST;
							bm_d         = 1'b0;
							bc_d         = 1'b0;
							hn_d         = 1'b0;
						end else begin
							cmd.done    = 1'b1;
							cmd.status  = end_status(phase_q, hn_q, err_q);
							cmd.clr_cnt = 1'b1;
							phase_d     = PH_SCHEME;
							err_d       = ST_OK;
							bm_d        = 1'b0;
							bc_d        = 1'b0;
							hn_d        = 1'b0;
						end
					end else begin
						unique case (phase_q)
							PH_SCHEME: begin
								if (stat.cls.colon) begin
									phase_d = PH_SLASH1;
								end else if (stat.cls.scheme_ok) begin
									cmd.emit  = 1'b1;
									cmd.lower = 1'b1;
									cmd.tag   = TAG_SCHEME;
								end else begin
									phase_d = PH_SCHEME_BAD;
								end
							end
							PH_SCHEME_BAD: begin
								if (stat.cls.colon) begin
									phase_d = PH_ERR;
									err_d   = ST_BAD_SCHEME;
								end
							end
							PH_SLASH1: begin
								if (stat.cls.slash) begin
									phase_d = PH_SLASH2;
								end else begin
									phase_d = PH_ERR;
									err_d   = ST_NO_SLASH;
								end
							end
							PH_SLASH2: begin
								if (stat.cls.slash) begin
									phase_d     = PH_AUTH;
									cmd.clr_cnt = 1'b1;
								end else begin
									phase_d = PH_ERR;
									err_d   = ST_NO_SLASH;
								end
							end
							PH_AUTH: begin
								if (stat.cls.at) begin
									cmd.run_end  = 1'b0;
									cmd.rd_start = 1'b1;
									seq_d        = SQ_REPLAY;
									kind_d       = RK_USER;
									split_d      = 1'b0;
								end else if (stat.cls.slash) begin
									cmd.run_end  = 1'b0;
									cmd.rd_start = 1'b1;
									seq_d        = SQ_REPLAY;
									kind_d       = RK_HOST;
									phase_d      = PH_HOST;
									bm_d         = 1'b0;
									bc_d         = 1'b0;
									hn_d         = 1'b0;
								end else if (stat.full) begin
									phase_d = PH_ERR;
									err_d   = ST_OVERFLOW;
								end else begin
									cmd.wr = 1'b1;
								end
							end
							PH_HOST, PH_PORT, PH_PATH, PH_QUERY, PH_FRAG: begin
								phase_d  = f_phase;
								bm_d     = f_bm;
								bc_d     = f_bc;
								hn_d     = f_hn;
								err_d    = f_err;
								cmd.emit = f_emit;
								cmd.tag  = f_tag;
							end
							default: begin
								phase_d = PH_ERR;
							end
						endcase
					end
				end
			end
			SQ_REPLAY: begin
				if (stat.pend_ok) begin
					cmd.step = 1'b1;
					if (stat.rv) begin
						cmd.rd_go = 1'b1;
						if (kind_q == RK_USER) begin
							if (!split_q && stat.cls.colon) begin
								split_d = 1'b1;
							end else begin
								cmd.emit = 1'b1;
								cmd.tag  = split_q ? TAG_PASS : TAG_USER;
							end
						end else begin
							phase_d  = f_phase;
							bm_d     = f_bm;
							bc_d     = f_bc;
							hn_d     = f_hn;
							err_d    = f_err;
							cmd.emit = f_emit;
							cmd.tag  = f_tag;
						end
					end else if (stat.more) begin
						cmd.rd_go = 1'b1;
					end else begin
						cmd.run_end = 1'b1;
						cmd.clr_cnt = 1'b1;
						seq_d       = SQ_RUN;
						unique case (kind_q)
							RK_USER: begin
								phase_d = PH_HOST;
								bm_d    = 1'b0;
								bc_d    = 1'b0;
								hn_d    = 1'b0;
							end
							RK_HOST: begin
								phase_d  = f_phase;
								bm_d     = f_bm;
								bc_d     = f_bc;
								hn_d     = f_hn;
								err_d    = f_err;
								cmd.emit = f_emit;
								cmd.tag  = f_tag;
							end
							default: begin
								cmd.done   = 1'b1;
								cmd.status = end_status(phase_q, hn_q, err_q);
								phase_d    = PH_SCHEME;
								err_d      = ST_OK;
								bm_d       = 1'b0;
								bc_d       = 1'b0;
								hn_d       = 1'b0;
							end
						endcase
					end
				end
			end
			default: begin
				seq_d = SQ_RUN;
			end
		endcase
	end

endmodule

@@ design/url_field_splitter.sv @@
// Channel | Handshake             | Payload
// url     | url_valid / url_stall | url_data (url_req_t): in_byte, is_end
// seg     | seg_valid / seg_stall | seg_data (seg_res_t): one tagged byte or done
//
// One byte per cycle outside the authority part while seg is not stalled.
// After '@', '/' or the end marker closes an authority, url_stall holds
// while the authority RAM's registered read port replays the stored bytes,
// one per cycle while seg is not stalled.
// Reset clears all control state; authority RAM contents are never read past
// the fill count. A pending slot plus the output register decouple seg_stall.
module url_field_splitter import ufs_pkg::*; #(
	parameter int AUTH_DEPTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     url_valid,
	output logic     url_stall,
	input  url_req_t url_data,
	output logic     seg_valid,
	input  logic     seg_stall,
	output seg_res_t seg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     replay;

	ufs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_valid(url_valid),
		.url_stall(url_stall),
		.replay   (replay),
		.stat     (stat),
		.cmd      (cmd)
	);

	ufs_dp #(
		.AUTH_DEPTH(AUTH_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.url_data (url_data),
		.replay   (replay),
		.cmd      (cmd),
		.stat     (stat),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_data (seg_data)
	);

endmodule

@@ design/ufs_checker.sv @@
module ufs_checker import ufs_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     url_valid,
	input logic     url_stall,
	input url_req_t url_data,
	input logic     seg_valid,
	input logic     seg_stall,
	input seg_res_t seg_data
);

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		url_valid && url_stall |=> url_valid && $stable(url_data))
		else $error("request changed while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_stall |=> seg_valid && $stable(seg_data))
		else $error("result changed while stalled");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.done_res |-> !seg_data.byte_valid && seg_data.last_of_run)
		else $error("done result malformed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid |-> (seg_data.byte_valid != seg_data.done_res))
		else $error("result neither content nor done");

	a_scheme_lower: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_data.byte_valid && seg_data.field_tag == TAG_SCHEME |->
			seg_data.status == ST_OK &&
			!(seg_data.out_byte >= CH_UPPER_A && seg_data.out_byte <= CH_UPPER_Z))
		else $error("scheme byte not lowercased");

endmodule

bind url_field_splitter ufs_checker u_ufs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.url_valid(url_valid),
	.url_stall(url_stall),
	.url_data (url_data),
	.seg_valid(seg_valid),
	.seg_stall(seg_stall),
	.seg_data (seg_data)
);

@@ dv/testbench.sv @@
module testbench import ufs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AUTH_DEPTH = 32;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     url_valid = 1'b0;
	logic     url_stall;
	url_req_t url_data = '0;
	logic     seg_valid;
	logic     seg_stall = 1'b0;
	seg_res_t seg_data;

	url_field_splitter #(
		.AUTH_DEPTH(AUTH_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.url_valid(url_valid),
		.url_stall(url_stall),
		.url_data(url_data),
		.seg_valid(seg_valid),
		.seg_stall(seg_stall),
		.seg_data(seg_data)
	);

	always #6ns clk = ~clk;

	url_req_t pending_url [$];
	seg_res_t owed_segs [$];
	seg_res_t run_segs [$];
	int       n_bad = 0;

	phase_t     url_phase = PH_SCHEME;
	logic [2:0] url_err = ST_OK;
	logic [7:0] auth_buf [AUTH_DEPTH];
	int         auth_len = 0;
	logic       in_bracket = 1'b0;
	logic       bracket_done = 1'b0;
	logic       host_has_byte = 1'b0;

	function automatic void put_seg(logic [7:0] b, logic [2:0] tag, logic done, logic [2:0] st);
		seg_res_t r;
		r.out_byte    = b;
		r.field_tag   = tag;
		r.byte_valid  = ~done;
		r.done_res    = done;
		r.status      = st;
		r.last_of_run = 1'b0;
		run_segs.push_back(r);
	endfunction

	function automatic void set_err(logic [2:0] code);
		url_err   = code;
		url_phase = PH_ERR;
	endfunction

	function automatic void open_host();
		url_phase     = PH_HOST;
		in_bracket    = 1'b0;
		bracket_done  = 1'b0;
		host_has_byte = 1'b0;
	endfunction

	function automatic void tail_byte(logic [7:0] b);
		case (url_phase)
			PH_HOST: begin
				if (in_bracket && !bracket_done) begin
					put_seg(b, TAG_HOST, 1'b0, ST_OK);
					if (b == CH_RBR)
						bracket_done = 1'b1;
				end else if (bracket_done) begin
					if (b == CH_COLON)
						url_phase = PH_PORT;
					else if (b == CH_SLASH)
						url_phase = PH_PATH;
					else
						set_err(ST_BAD_AFTER);
				end else if (b == CH_COLON || b == CH_SLASH) begin
					if (!host_has_byte)
						set_err(ST_EMPTY_HOST);
					else
						url_phase = (b == CH_COLON) ? PH_PORT : PH_PATH;
				end else begin
					if (!host_has_byte && b == CH_LBR)
						in_bracket = 1'b1;
					put_seg(b, TAG_HOST, 1'b0, ST_OK);
					host_has_byte = 1'b1;
				end
			end
			PH_PORT: begin
				if (b == CH_SLASH)
					url_phase = PH_PATH;
				else
					put_seg(b, TAG_PORT, 1'b0, ST_OK);
			end
			PH_PATH: begin
				if (b == CH_QMARK)
					url_phase = PH_QUERY;
				else if (b == CH_HASH)
					url_phase = PH_FRAG;
				else
					put_seg(b, TAG_PATH, 1'b0, ST_OK);
			end
			PH_QUERY: begin
				if (b == CH_HASH)
					url_phase = PH_FRAG;
				else
					put_seg(b, TAG_QUERY, 1'b0, ST_OK);
			end
			PH_FRAG: put_seg(b, TAG_FRAG, 1'b0, ST_OK);
			default: ;
		endcase
	endfunction

	function automatic void flush_host();
		int n;
		n = auth_len;
		open_host();
		for (int i = 0; i < n; i++)
			tail_byte(auth_buf[i]);
		auth_len = 0;
	endfunction

	function automatic void flush_user();
		bit split;
		split = 1'b0;
		for (int i = 0; i < auth_len; i++) begin
			if (!split && auth_buf[i] == CH_COLON)
				split = 1'b1;
			else
				put_seg(auth_buf[i], split ? TAG_PASS : TAG_USER, 1'b0, ST_OK);
		end
		auth_len = 0;
		open_host();
	endfunction

	function automatic void parse_request(url_req_t req);
		logic [7:0] b;
		logic [2:0] st;
		seg_res_t   r;
		b = req.in_byte;
		run_segs.delete();
		if (req.is_end) begin
			if (url_phase == PH_AUTH)
				flush_host();
			case (url_phase)
				PH_SCHEME, PH_SCHEME_BAD: st = ST_NO_COLON;
				PH_SLASH1, PH_SLASH2: st = ST_NO_SLASH;
				PH_HOST: st = host_has_byte ? ST_OK : ST_EMPTY_HOST;
				PH_PORT, PH_PATH, PH_QUERY, PH_FRAG: st = ST_OK;
				default: st = url_err;
			endcase
			put_seg(8'h00, TAG_SCHEME, 1'b1, st);
			url_phase = PH_SCHEME;
			url_err   = ST_OK;
			auth_len  = 0;
			in_bracket    = 1'b0;
			bracket_done  = 1'b0;
			host_has_byte = 1'b0;
		end else begin
			case (url_phase)
				PH_SCHEME: begin
					if (b == CH_COLON)
						url_phase = PH_SLASH1;
					else if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
						put_seg(b + CASE_OFFSET, TAG_SCHEME, 1'b0, ST_OK);
					else if ((b >= CH_LOWER_A && b <= CH_LOWER_Z) || b == CH_PLUS
							|| b == CH_MINUS || b == CH_DOT)
						put_seg(b, TAG_SCHEME, 1'b0, ST_OK);
					else
						url_phase = PH_SCHEME_BAD;
				end
				PH_SCHEME_BAD: begin
					if (b == CH_COLON)
						set_err(ST_BAD_SCHEME);
				end
				PH_SLASH1: begin
					if (b == CH_SLASH)
						url_phase = PH_SLASH2;
					else
						set_err(ST_NO_SLASH);
				end
				PH_SLASH2: begin
					if (b == CH_SLASH) begin
						url_phase = PH_AUTH;
						auth_len  = 0;
					end else begin
						set_err(ST_NO_SLASH);
					end
				end
				PH_AUTH: begin
					if (b == CH_AT) begin
						flush_user();
					end else if (b == CH_SLASH) begin
						flush_host();
						tail_byte(b);
					end else if (auth_len >= AUTH_DEPTH) begin
						set_err(ST_OVERFLOW);
					end else begin
						auth_buf[auth_len] = b;
						auth_len++;
					end
				end
				PH_HOST, PH_PORT, PH_PATH, PH_QUERY, PH_FRAG: tail_byte(b);
				default: url_phase = PH_ERR;
			endcase
		end
		foreach (run_segs[i]) begin
			r = run_segs[i];
			r.last_of_run = (i == run_segs.size() - 1);
			owed_segs.push_back(r);
		end
	endfunction

	function automatic void push_byte(logic [7:0] b);
		url_req_t req;
		req.in_byte = b;
		req.is_end  = 1'b0;
		pending_url.push_back(req);
	endfunction

	function automatic void push_end();
		url_req_t req;
		req.in_byte = 8'($urandom_range(0, 255));
		req.is_end  = 1'b1;
		pending_url.push_back(req);
	endfunction

	function automatic void push_text(string s);
		foreach (s[i])
			push_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_byte(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic [7:0] d);
		logic [7:0] v;
		do
			v = 8'($urandom_range(0, 255));
		while (v == a || v == b || v == c || v == d);
		return v;
	endfunction

	function automatic logic [7:0] scheme_byte();
		int k;
		k = $urandom_range(0, 54);
		if (k < 26)
			return CH_UPPER_A + 8'(k);
		else if (k < 52)
			return CH_LOWER_A + 8'(k - 26);
		else if (k == 52)
			return CH_PLUS;
		else if (k == 53)
			return CH_MINUS;
		return CH_DOT;
	endfunction

	function automatic void add_url();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 10))
				push_byte(8'($urandom_range(0, 255)));
			push_end();
			return;
		end
		repeat ($urandom_range(0, 6))
			push_byte(scheme_byte());
		if ($urandom_range(0, 19) == 0)
			push_byte(pick_byte(CH_COLON, CH_COLON, CH_COLON, CH_COLON));
		if ($urandom_range(0, 24) == 0) begin
			push_end();
			return;
		end
		push_byte(CH_COLON);
		repeat (2)
			push_byte(($urandom_range(0, 29) == 0) ?
				pick_byte(CH_SLASH, CH_SLASH, CH_SLASH, CH_SLASH) : CH_SLASH);
		if ($urandom_range(0, 14) == 0) begin
			repeat ($urandom_range(AUTH_DEPTH - 2, AUTH_DEPTH + 4))
				push_byte(pick_byte(CH_COLON, CH_SLASH, CH_AT, CH_LBR));
		end else begin
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(0, 6))
					push_byte(pick_byte(CH_COLON, CH_SLASH, CH_AT, CH_AT));
				if ($urandom_range(0, 1)) begin
					push_byte(CH_COLON);
					repeat ($urandom_range(0, 6))
						push_byte(pick_byte(CH_SLASH, CH_AT, CH_AT, CH_AT));
				end
				push_byte(CH_AT);
			end
			case ($urandom_range(0, 7))
				0: begin
					push_byte(CH_LBR);
					repeat ($urandom_range(0, 8))
						push_byte(pick_byte(CH_SLASH, CH_AT, CH_RBR, CH_RBR));
					push_byte(CH_RBR);
					if ($urandom_range(0, 4) == 0)
						push_byte(pick_byte(CH_COLON, CH_SLASH, CH_AT, CH_AT));
				end
				1: ;
				default: begin
					repeat ($urandom_range(1, 12))
						push_byte(pick_byte(CH_COLON, CH_SLASH, CH_AT, CH_LBR));
				end
			endcase
			if ($urandom_range(0, 2) == 0) begin
				push_byte(CH_COLON);
				repeat ($urandom_range(0, 5))
					push_byte(pick_byte(CH_SLASH, CH_AT, CH_AT, CH_AT));
			end
		end
		if ($urandom_range(0, 1)) begin
			push_byte(CH_SLASH);
			repeat ($urandom_range(0, 10))
				push_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 2) == 0) begin
			push_byte(CH_QMARK);
			repeat ($urandom_range(0, 6))
				push_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 2) == 0) begin
			push_byte(CH_HASH);
			repeat ($urandom_range(0, 6))
				push_byte(8'($urandom_range(0, 255)));
		end
		push_end();
	endfunction

	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_valid  <= 1'b0;
			url_data   <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (url_valid && !url_stall)
				parse_request(url_data);
			if (!url_valid || !url_stall) begin
				if (gap_left != 0 || pending_url.size() == 0) begin
					url_valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					url_valid <= 1'b1;
					url_data  <= pending_url.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
		end
	end

	int stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		seg_res_t want;
		if (!arst_n) begin
			seg_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (seg_valid && !seg_stall) begin
				if (owed_segs.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected segment: byte %h tag %0d valid %b done %b st %0d last %b",
							seg_data.out_byte, seg_data.field_tag, seg_data.byte_valid,
							seg_data.done_res, seg_data.status, seg_data.last_of_run);
				end else begin
					want = owed_segs.pop_front();
					if (seg_data.out_byte !== want.out_byte || seg_data.field_tag !== want.field_tag
							|| seg_data.byte_valid !== want.byte_valid
							|| seg_data.done_res !== want.done_res
							|| seg_data.status !== want.status
							|| seg_data.last_of_run !== want.last_of_run) begin
						n_bad++;
						if (n_bad <= 10)
							$display({"segment mismatch: got byte %h tag %0d valid %b done %b st %0d ",
								"last %b, want byte %h tag %0d valid %b done %b st %0d last %b"},
								seg_data.out_byte, seg_data.field_tag, seg_data.byte_valid,
								seg_data.done_res, seg_data.status, seg_data.last_of_run,
								want.out_byte, want.field_tag, want.byte_valid, want.done_res,
								want.status, want.last_of_run);
					end
				end
			end
			if (stall_left == 0) begin
				if (seg_stall) begin
					seg_stall  <= 1'b0;
					stall_left <= $urandom_range(1, 30);
				end else begin
					seg_stall  <= 1'b1;
					stall_left <= $urandom_range(1, 5);
				end
			end else begin
				stall_left <= stall_left - 1;
			end
		end
	end

	initial begin
		push_end();
		pending_url[0].in_byte = 8'hFF;
		push_text("a:x");
		push_end();
		push_byte(8'h00);
		push_byte(CH_COLON);
		push_end();
		push_text("A://@/");
		push_end();
		push_text("://[]x");
		push_end();
		while (pending_url.size() < 480)
			add_url();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_url.size() != 0 || url_valid)
			@(posedge clk);
		while (owed_segs.size() != 0)
			@(posedge clk);
		repeat (AUTH_DEPTH + 8) @(posedge clk);

		if (owed_segs.size() != 0)
			$display("%0d expected segments never arrived", owed_segs.size());
		if (n_bad == 0 && owed_segs.size() == 0) begin
			$display("url_field_splitter test passed");
		end else begin
			$display("url_field_splitter test failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("url_field_splitter test failed");
		$finish;
	end

endmodule

@@ files.f @@
design/ufs_pkg.sv
design/ufs_ram.sv
design/ufs_dp.sv
design/ufs_ctrl.sv
design/url_field_splitter.sv
design/ufs_checker.sv
dv/testbench.sv
